// ===== sv/ewma_pkg.sv =====
`default_nettype none

package ewma_pkg;

	// Fixed field and state widths
	localparam int unsigned CH_W     = 8;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned SAMP_MAX = 24;   // widest sample the datapath carries
	localparam int unsigned ALPHA_W  = 16;
	localparam int unsigned MEAN_W   = 32;
	localparam int unsigned VAR_W    = 48;
	localparam int unsigned MEM_W    = MEAN_W + VAR_W;
	localparam int unsigned DELTA_W  = SAMP_MAX + 17;
	localparam int unsigned STAT_W   = 25;
	localparam int unsigned ROOT_W   = 24;
	localparam int unsigned SUM_W    = 43;

	localparam logic [VAR_W-1:0] VAR_MAX = '1;

	// Configuration register indexes (paddr[2])
	localparam logic REG_ALPHA = 1'b0;
	localparam logic REG_MODE  = 1'b1;

	// Output mode codes
	localparam logic MODE_MEAN = 1'b0;
	localparam logic MODE_DEV  = 1'b1;

	typedef struct packed {
		logic [ALPHA_W-1:0] alpha;
		logic               mode;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [VAR_W-1:0] radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} sqrt_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_MUL_M,
		ST_MUL_TM,
		ST_TERM,
		ST_SUM,
		ST_SCL_LO,
		ST_SCL_HI,
		ST_VAR,
		ST_WRITE,
		ST_ROOT,
		ST_DONE
	} state_t;

	// Saturate a signed sum to the signed 32-bit mean range
	function automatic logic [MEAN_W-1:0] sat_mean(input logic signed [SUM_W-1:0] x);
		logic hi_ok;
		logic lo_ok;
		hi_ok = (x[SUM_W-1:MEAN_W-1] == '0);
		lo_ok = (x[SUM_W-1:MEAN_W-1] == '1);
		if (hi_ok || lo_ok) begin
			sat_mean = x[MEAN_W-1:0];
		end else if (x[SUM_W-1]) begin
			sat_mean = {1'b1, {(MEAN_W-1){1'b0}}};
		end else begin
			sat_mean = {1'b0, {(MEAN_W-1){1'b1}}};
		end
	endfunction

endpackage

`default_nettype wire

// ===== sv/ewma_mean_stddev_tracker.sv =====
// Channel   Direction  Handshake            Payload
// in        request    in_valid / in_stall  channel_index, sample_value
// out       result     out_valid / out_stall result_channel, statistic_value
// cfg       APB write  psel/penable/pwrite  paddr, pwdata (prdata on reads)
//
// One request at a time: in_stall is low only in idle. A seed skips the multiply
// passes and an out-of-range channel goes straight to the result; deviation mode
// adds the bit-per-cycle root. Six passes share one 32x32 multiplier.
// Reset sets the seed flags and resets config; the RAM is seeded before it is read.
// A result held by out_stall sits in the output register; the next request
// still runs and waits only at its own end if the result is still unread.
`default_nettype none

module ewma_mean_stddev_tracker #(
	parameter int unsigned CHANNELS    = 256,
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// sample requests
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [ewma_pkg::CH_W-1:0]          channel_index,
	input  wire logic signed [ewma_pkg::SAMPLE_W-1:0] sample_value,
	// results
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [ewma_pkg::CH_W-1:0]               result_channel,
	output logic signed [ewma_pkg::STAT_W-1:0]      statistic_value,
	// configuration
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [2:0]                         paddr,
	input  wire logic [31:0]                        pwdata,
	output logic [31:0]                             prdata,
	output logic                                    pready
);

	// only the first 256 channels are reachable through the index field
	localparam int unsigned ENTRIES = (CHANNELS < 256) ? CHANNELS : 256;
	localparam int unsigned ENT_AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [10:0] CH_LIM  = 11'(CHANNELS);
	localparam int unsigned SW      = ewma_pkg::SAMP_MAX;
	localparam int unsigned DW      = ewma_pkg::DELTA_W;
	localparam int unsigned MW      = ewma_pkg::MEAN_W;
	localparam int unsigned VW      = ewma_pkg::VAR_W;
	localparam logic [SW-1:0] SMASK = (SW'(1) << SAMPLE_BITS) - SW'(1);

	ewma_pkg::cfg_t      cfg;
	ewma_pkg::sqrt_req_t sq_req;
	ewma_pkg::sqrt_rsp_t sq_rsp;
	ewma_pkg::state_t    state_q, state_d;

	// control
	logic accept;
	logic ram_we;
	logic out_load;
	logic [ENTRIES-1:0] needs_seed_q;

	// item registers
	logic [ewma_pkg::CH_W-1:0] ch_q;
	logic [SW-1:0]             samp_q;
	logic                      oor_q;
	logic                      seed_q;

	// datapath registers
	logic [MW-1:0]  mean_old_q;
	logic [VW-1:0]  var_old_q;
	logic [DW-1:0]  mag_q;
	logic           neg_q;
	logic [63:0]    prod_q;
	logic [VW-1:0]  lo_q;
	logic [56:0]    p_q;
	logic [41:0]    inc_q;
	logic [VW-1:0]  term_q;
	logic [VW-1:0]  sum_q;
	logic [MW-1:0]  mean_new_q;
	logic [VW-1:0]  var_new_q;

	// output register
	logic                               out_valid_q;
	logic [ewma_pkg::CH_W-1:0]          res_ch_q;
	logic [ewma_pkg::STAT_W-1:0]        stat_q;

	// combinational helpers
	logic [SW-1:0]            samp_raw;
	logic [SW-1:0]            samp_ext;
	logic [39:0]              samp_sh;
	logic [MW-1:0]            rd_mean;
	logic [VW-1:0]            rd_var;
	logic [DW-1:0]            delta;
	logic [31:0]              mul_a;
	logic [31:0]              mul_b;
	logic [63:0]              mul_p;
	logic [16:0]              w_keep;
	logic [40:0]              p_int;
	logic [VW:0]              sum_wide;
	logic [64:0]              scl_tot;
	logic [ewma_pkg::STAT_W-1:0] stat_d;
	logic [ewma_pkg::MEM_W-1:0]  ram_rdata;
	logic [ENT_AW-1:0]        ch_addr;
	logic [ENT_AW-1:0]        ch_q_addr;

	ewma_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	assign ch_addr   = channel_index[ENT_AW-1:0];
	assign ch_q_addr = ch_q[ENT_AW-1:0];

	// per-channel mean and variance store
	ewma_ram #(
		.WIDTH(ewma_pkg::MEM_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ch_q_addr),
		.wdata({mean_new_q, var_new_q}),
		.re   (accept),
		.raddr(ch_addr),
		.rdata(ram_rdata)
	);

	ewma_isqrt u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (sq_req),
		.rsp   (sq_rsp)
	);

	assign accept = in_valid && !in_stall;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ewma_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control
	always_comb begin
		state_d         = state_q;
		in_stall        = 1'b1;
		ram_we          = 1'b0;
		sq_req.start    = 1'b0;
		sq_req.radicand = var_new_q;
		out_load        = 1'b0;
		unique case (state_q)
			ewma_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ewma_pkg::ST_LOAD;
				end
			end
			ewma_pkg::ST_LOAD: begin
				if (oor_q) begin
					state_d = ewma_pkg::ST_DONE;
				end else if (seed_q) begin
					state_d = ewma_pkg::ST_WRITE;
				end else begin
					state_d = ewma_pkg::ST_MUL_LO;
				end
			end
			ewma_pkg::ST_MUL_LO: state_d = ewma_pkg::ST_MUL_HI;
			ewma_pkg::ST_MUL_HI: state_d = ewma_pkg::ST_MUL_M;
			ewma_pkg::ST_MUL_M:  state_d = ewma_pkg::ST_MUL_TM;
			ewma_pkg::ST_MUL_TM: state_d = ewma_pkg::ST_TERM;
			ewma_pkg::ST_TERM:   state_d = ewma_pkg::ST_SUM;
			ewma_pkg::ST_SUM:    state_d = ewma_pkg::ST_SCL_LO;
			ewma_pkg::ST_SCL_LO: state_d = ewma_pkg::ST_SCL_HI;
			ewma_pkg::ST_SCL_HI: state_d = ewma_pkg::ST_VAR;
			ewma_pkg::ST_VAR:    state_d = ewma_pkg::ST_WRITE;
			ewma_pkg::ST_WRITE: begin
				ram_we = 1'b1;
				if (cfg.mode == ewma_pkg::MODE_DEV) begin
					sq_req.start = 1'b1;
					state_d      = ewma_pkg::ST_ROOT;
				end else begin
					state_d = ewma_pkg::ST_DONE;
				end
			end
			ewma_pkg::ST_ROOT: begin
				if (sq_rsp.done) begin
					state_d = ewma_pkg::ST_DONE;
				end
			end
			ewma_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ewma_pkg::ST_IDLE;
				end
			end
			default: state_d = ewma_pkg::ST_IDLE;
		endcase
	end

	// sample: low SAMPLE_BITS of the field as two's complement
	assign samp_raw = {{(SW-ewma_pkg::SAMPLE_W){1'b0}}, sample_value} & SMASK;
	assign samp_ext = samp_raw[SAMPLE_BITS-1] ? (samp_raw | ~SMASK) : samp_raw;
	assign samp_sh  = {samp_q, 16'h0000};

	assign rd_mean = ram_rdata[ewma_pkg::MEM_W-1:VW];
	assign rd_var  = ram_rdata[VW-1:0];
	assign delta   = {samp_sh[39], samp_sh} - {{(DW-MW){rd_mean[MW-1]}}, rd_mean};

	// shared multiplier operand select
	assign w_keep = 17'h10000 - {1'b0, cfg.alpha};
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ewma_pkg::ST_MUL_LO: begin
				mul_a = mag_q[31:0];
				mul_b = {16'h0000, cfg.alpha};
			end
			ewma_pkg::ST_MUL_HI: begin
				mul_a = {{(64-DW){1'b0}}, mag_q[DW-1:32]};
				mul_b = {16'h0000, cfg.alpha};
			end
			ewma_pkg::ST_MUL_M: begin
				mul_a = mag_q[39:8];
				mul_b = {16'h0000, cfg.alpha};
			end
			ewma_pkg::ST_MUL_TM: begin
				mul_a = prod_q[47:16];
				mul_b = mag_q[39:8];
			end
			ewma_pkg::ST_SCL_LO: begin
				mul_a = {8'h00, sum_q[23:0]};
				mul_b = {15'h0000, w_keep};
			end
			ewma_pkg::ST_SCL_HI: begin
				mul_a = {8'h00, sum_q[47:24]};
				mul_b = {15'h0000, w_keep};
			end
			default: ;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign p_int    = p_q[56:16];
	assign sum_wide = {1'b0, var_old_q} + {1'b0, term_q};
	assign scl_tot  = {24'h000000, lo_q[40:0]} + {prod_q[40:0], 24'h000000};

	// capture request on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q   <= channel_index;
			samp_q <= samp_ext;
			oor_q  <= ({3'b000, channel_index} >= CH_LIM);
			seed_q <= needs_seed_q[ch_addr];
		end
	end

	// seed flags, set by reset, cleared on the first write of a channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needs_seed_q <= '1;
		end else if (ram_we) begin
			needs_seed_q[ch_q_addr] <= 1'b0;
		end
	end

	// update datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (state_q)
			ewma_pkg::ST_LOAD: begin
				mean_old_q <= rd_mean;
				var_old_q  <= rd_var;
				neg_q      <= delta[DW-1];
				mag_q      <= delta[DW-1] ? (~delta + 1'b1) : delta;
				mean_new_q <= ewma_pkg::sat_mean(
					{{(ewma_pkg::SUM_W-40){samp_sh[39]}}, samp_sh});
				var_new_q  <= '0;
			end
			ewma_pkg::ST_MUL_HI: lo_q <= prod_q[47:0];
			ewma_pkg::ST_MUL_M:  p_q  <= {9'h000, lo_q} + {prod_q[24:0], 32'h00000000};
			ewma_pkg::ST_MUL_TM: begin
				// floor shift of the signed product
				inc_q <= neg_q ? (42'd0 - {1'b0, p_int} - {41'd0, (p_q[15:0] != '0)})
				               : {1'b0, p_int};
			end
			ewma_pkg::ST_TERM: begin
				term_q     <= (prod_q[63:48] != '0) ? ewma_pkg::VAR_MAX : prod_q[47:0];
				mean_new_q <= ewma_pkg::sat_mean(
					{{(ewma_pkg::SUM_W-MW){mean_old_q[MW-1]}}, mean_old_q} +
					{inc_q[41], inc_q});
			end
			ewma_pkg::ST_SUM:    sum_q <= sum_wide[VW] ? ewma_pkg::VAR_MAX : sum_wide[VW-1:0];
			ewma_pkg::ST_SCL_HI: lo_q  <= prod_q[47:0];
			ewma_pkg::ST_VAR:    var_new_q <= scl_tot[63:16];
			default: ;
		endcase
	end

	// result value
	always_comb begin
		if (oor_q) begin
			stat_d = '0;
		end else if (cfg.mode == ewma_pkg::MODE_DEV) begin
			stat_d = {1'b0, sq_rsp.root};
		end else begin
			stat_d = {mean_new_q[MW-1], mean_new_q[MW-1:8]};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_ch_q <= ch_q;
			stat_q   <= stat_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign result_channel  = res_ch_q;
	assign statistic_value = stat_q;

endmodule

`default_nettype wire

// ===== sv/ewma_ram.sv =====
`default_nettype none

module ewma_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/ewma_cfg.sv =====
`default_nettype none

module ewma_cfg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output ewma_pkg::cfg_t   cfg
);

	logic [ewma_pkg::ALPHA_W-1:0] alpha_q;
	logic                         mode_q;
	logic                         wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ewma_pkg::ALPHA_W'(2);
			mode_q  <= ewma_pkg::MODE_MEAN;
		end else if (wr_en) begin
			unique case (paddr[2])
				ewma_pkg::REG_ALPHA: alpha_q <= pwdata[ewma_pkg::ALPHA_W-1:0];
				ewma_pkg::REG_MODE:  mode_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (paddr[2])
			ewma_pkg::REG_ALPHA: prdata = {{(32-ewma_pkg::ALPHA_W){1'b0}}, alpha_q};
			ewma_pkg::REG_MODE:  prdata = {31'b0, mode_q};
			default:             prdata = '0;
		endcase
	end

	assign cfg.alpha = alpha_q;
	assign cfg.mode  = mode_q;

endmodule

`default_nettype wire

// ===== sv/ewma_isqrt.sv =====
`default_nettype none

module ewma_isqrt (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  ewma_pkg::sqrt_req_t req,
	output ewma_pkg::sqrt_rsp_t rsp
);

	localparam int unsigned RW  = ewma_pkg::ROOT_W;
	localparam int unsigned VW  = ewma_pkg::VAR_W;
	localparam int unsigned REMW = RW + 2;
	localparam int unsigned CW  = $clog2(RW);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [VW-1:0]   rad_q;
	logic [REMW-1:0] rem_q;
	logic [RW-1:0]   root_q;

	logic [REMW-1:0] rem_sh;
	logic [REMW-1:0] trial;
	logic            fits;

	// one root bit per cycle: bring down two radicand bits, try root*4+1
	assign rem_sh = REMW'({rem_q, rad_q[VW-1:VW-2]});
	assign trial  = {root_q, 2'b01};
	assign fits   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// iteration registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= req.radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[VW-3:0], 2'b00};
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[RW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int CLK_PERIOD  = 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int NUM_CH      = 256;
	localparam int RAND_PHASES = 6;
	localparam int PHASE_ITEMS = 225;

	typedef struct packed {
		logic [ewma_pkg::CH_W-1:0]            ch;
		logic signed [ewma_pkg::SAMPLE_W-1:0] sample;
	} sample_req_t;

	typedef struct packed {
		logic [ewma_pkg::CH_W-1:0]   ch;
		logic [ewma_pkg::STAT_W-1:0] value;
	} stat_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// block inputs, known from time zero
	logic                                 in_valid = 1'b0;
	logic [ewma_pkg::CH_W-1:0]            channel_index = '0;
	logic signed [ewma_pkg::SAMPLE_W-1:0] sample_value = '0;
	logic                                 out_stall = 1'b0;
	logic                                 psel = 1'b0;
	logic                                 penable = 1'b0;
	logic                                 pwrite = 1'b0;
	logic [2:0]                           paddr = '0;
	logic [31:0]                          pwdata = '0;

	logic                                 in_stall;
	logic                                 out_valid;
	logic [ewma_pkg::CH_W-1:0]            result_channel;
	logic signed [ewma_pkg::STAT_W-1:0]   statistic_value;
	logic [31:0]                          prdata;
	logic                                 pready;

	ewma_mean_stddev_tracker dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.channel_index   (channel_index),
		.sample_value    (sample_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.result_channel  (result_channel),
		.statistic_value (statistic_value),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	// shadow of the block's configuration and per-channel statistics
	logic [ewma_pkg::ALPHA_W-1:0]       alpha_cfg = 16'd2;
	logic                               mode_cfg = ewma_pkg::MODE_MEAN;
	logic signed [ewma_pkg::MEAN_W-1:0] chan_mean [NUM_CH];
	logic [ewma_pkg::VAR_W-1:0]         chan_var [NUM_CH];
	logic                               chan_unseeded [NUM_CH];
	int                                 trend [NUM_CH];

	sample_req_t  pending_samples[$];
	stat_result_t expected_stats[$];

	int issued = 0;
	int accepted = 0;
	int checked = 0;
	int errors = 0;
	int cycles = 0;
	int gap_pct = 21;
	int stall_pct = 21;
	int dev_checked = 0;

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic logic signed [ewma_pkg::MEAN_W-1:0] clamp_mean(longint x);
		if (x > 64'sd2147483647)
			return 32'sh7fffffff;
		if (x < -64'sd2147483648)
			return 32'sh80000000;
		return ewma_pkg::MEAN_W'(x);
	endfunction

	// Update one channel's mean and variance, return the statistic it reports
	function automatic logic [ewma_pkg::STAT_W-1:0] update_channel_stats(
			logic [ewma_pkg::CH_W-1:0] ch, logic signed [ewma_pkg::SAMPLE_W-1:0] smp);
		longint s;
		longint delta;
		logic [63:0] mag, m, t, term, sum, var_cap, root, trial;
		logic [81:0] scaled;
		logic signed [ewma_pkg::STAT_W-1:0] stat;
		var_cap = 64'(ewma_pkg::VAR_MAX);
		s = smp;
		if (chan_unseeded[ch]) begin
			// first sample seeds the mean, variance starts at zero
			chan_mean[ch] = clamp_mean(s <<< 16);
			chan_var[ch] = '0;
			chan_unseeded[ch] = 1'b0;
		end else begin
			delta = (s <<< 16) - longint'(chan_mean[ch]);
			mag = (delta < 0) ? 64'(-delta) : 64'(delta);
			m = mag >> 8;
			t = (m * 64'(alpha_cfg)) >> 16;
			chan_mean[ch] = clamp_mean(longint'(chan_mean[ch]) +
				((delta * longint'(alpha_cfg)) >>> 16));
			// a*delta^2 term, saturating
			if (t != 0 && m > var_cap / t)
				term = var_cap;
			else
				term = t * m;
			if (term > var_cap)
				term = var_cap;
			sum = 64'(chan_var[ch]) + term;
			if (sum > var_cap)
				sum = var_cap;
			scaled = (82'd65536 - 82'(alpha_cfg)) * 82'(sum);
			chan_var[ch] = ewma_pkg::VAR_W'(scaled >> 16);
		end
		if (mode_cfg == ewma_pkg::MODE_MEAN) begin
			stat = ewma_pkg::STAT_W'(chan_mean[ch] >>> 8);
		end else begin
			// floor square root, 24 result bits
			root = '0;
			for (int b = 23; b >= 0; b--) begin
				trial = root | (64'd1 << b);
				if (trial * trial <= 64'(chan_var[ch]))
					root = trial;
			end
			stat = ewma_pkg::STAT_W'(root);
		end
		return stat;
	endfunction

	// Request driver: predicts on accept, refills from the pending queue
	always @(posedge clk or negedge arst_n) begin : drive_requests
		sample_req_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			channel_index <= '0;
			sample_value <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_stats.push_back(stat_result_t'{ch: channel_index,
					value: update_channel_stats(channel_index, sample_value)});
				accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_samples.size() > 0 && $urandom_range(99) >= gap_pct) begin
					nxt = pending_samples.pop_front();
					in_valid <= 1'b1;
					channel_index <= nxt.ch;
					sample_value <= nxt.sample;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result side backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Result checker
	always @(posedge clk) begin : check_results
		stat_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_stats.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: ch=%0d stat=%0d", $time,
					result_channel, statistic_value);
			end else begin
				e = expected_stats.pop_front();
				if (result_channel !== e.ch) begin
					errors++;
					$display("%0t: result_channel expected %0d actual %0d", $time,
						e.ch, result_channel);
				end
				if (statistic_value !== e.value) begin
					errors++;
					$display("%0t: statistic_value ch=%0d expected %0d actual %0d", $time,
						e.ch, $signed(e.value), statistic_value);
				end
				if (mode_cfg == ewma_pkg::MODE_DEV)
					dev_checked++;
			end
			checked++;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d of %0d results seen", $time, checked, issued);
			$display("ewma_mean_stddev_tracker: mismatch");
			$finish;
		end
	end

	task automatic queue_sample(input logic [ewma_pkg::CH_W-1:0] ch,
			input logic signed [ewma_pkg::SAMPLE_W-1:0] smp);
		pending_samples.push_back(sample_req_t'{ch: ch, sample: smp});
		issued++;
	endtask

	// Random traffic: mostly tracked channels with noisy samples around a
	// per-channel level, plus arbitrary samples and full-scale swings
	task automatic queue_random(input int n);
		int pick, v, spread;
		logic [ewma_pkg::CH_W-1:0] ch;
		logic signed [ewma_pkg::SAMPLE_W-1:0] smp;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				if ($urandom_range(9) == 0)
					ch = ewma_pkg::CH_W'($urandom_range(255, 240));
				else
					ch = ewma_pkg::CH_W'($urandom_range(15));
				if ($urandom_range(19) == 0)
					trend[ch] = int'($urandom_range(65535)) - 32768;
				spread = 1 << $urandom_range(12);
				v = trend[ch] + int'($urandom_range(2 * spread)) - spread;
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
				smp = ewma_pkg::SAMPLE_W'(v);
			end else if (pick < 85) begin
				ch = ewma_pkg::CH_W'($urandom_range(255));
				smp = ewma_pkg::SAMPLE_W'($urandom_range(65535));
			end else begin
				ch = ewma_pkg::CH_W'($urandom_range(255));
				case ($urandom_range(3))
					0: smp = 16'sh7fff;
					1: smp = 16'sh8000;
					2: smp = 16'sh0000;
					default: smp = 16'shffff;
				endcase
			end
			queue_sample(ch, smp);
		end
	endtask

	// Block until every request has produced its result
	task automatic wait_drained();
		while (checked < issued)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic apb_write(input logic reg_sel, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_sel == ewma_pkg::REG_ALPHA)
			alpha_cfg = data[ewma_pkg::ALPHA_W-1:0];
		else
			mode_cfg = data[0];
	endtask

	task automatic set_config(input logic [ewma_pkg::ALPHA_W-1:0] alpha, input logic mode);
		wait_drained();
		apb_write(ewma_pkg::REG_ALPHA, 32'(alpha));
		apb_write(ewma_pkg::REG_MODE, 32'(mode));
	endtask

	// Main sequence
	initial begin
		logic [ewma_pkg::ALPHA_W-1:0] alpha;
		for (int i = 0; i < NUM_CH; i++) begin
			chan_unseeded[i] = 1'b1;
			chan_mean[i] = '0;
			chan_var[i] = '0;
			trend[i] = int'($urandom_range(65535)) - 32768;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: seeds at the sample extremes and at zero, then big swings
		queue_sample(8'd0, 16'sh7fff);
		queue_sample(8'd255, 16'sh8000);
		queue_sample(8'd1, 16'sh0000);
		queue_sample(8'd0, 16'sh8000);
		queue_sample(8'd255, 16'sh7fff);

		// full weight, deviation output
		set_config(16'hffff, ewma_pkg::MODE_DEV);
		queue_sample(8'd0, 16'sh8000);
		queue_sample(8'd0, 16'sh7fff);
		queue_sample(8'd255, 16'sh8000);
		queue_sample(8'd255, 16'sh7fff);
		queue_sample(8'd1, 16'sh7fff);
		queue_sample(8'd2, 16'sh1234);

		// smallest weight, mean output
		set_config(16'h0001, ewma_pkg::MODE_MEAN);
		queue_sample(8'd0, 16'sh0000);
		queue_sample(8'd1, 16'shffff);
		queue_sample(8'd3, 16'sh8000);
		queue_sample(8'd3, 16'sh7fff);

		// zero weight: statistics hold
		set_config(16'h0000, ewma_pkg::MODE_DEV);
		queue_sample(8'd0, 16'sh3039);
		queue_sample(8'd255, 16'shfffb);
		wait_drained();
		apb_write(ewma_pkg::REG_MODE, 32'(ewma_pkg::MODE_MEAN));
		queue_sample(8'd3, 16'sh8000);

		// random phases over a range of weights, alternating output mode
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: alpha = 16'hffff;
				1: alpha = 16'h0001;
				2: alpha = 16'h8000;
				3: alpha = 16'h1000;
				default: alpha = ewma_pkg::ALPHA_W'($urandom_range(65535, 1));
			endcase
			set_config(alpha, (p % 2 == 0) ? ewma_pkg::MODE_DEV : ewma_pkg::MODE_MEAN);
			gap_pct = (p == 2) ? 0 : 21;
			stall_pct = (p == 2) ? 0 : 21;
			if (p == 4) begin
				// hold off mid-phase until the block has drained
				queue_random(PHASE_ITEMS / 2);
				wait_drained();
				queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
			end else begin
				queue_random(PHASE_ITEMS);
			end
		end

		wait_drained();
		repeat (60) @(posedge clk);
		if (expected_stats.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, expected_stats.size());
		end
		$display("Ran %0d sample requests through %0d weight/mode settings;", accepted,
			RAND_PHASES + 5);
		$display("checked %0d results (%0d deviation), %0d errors", checked, dev_checked,
			errors);
		if (errors == 0)
			$display("ewma_mean_stddev_tracker: match");
		else
			$display("ewma_mean_stddev_tracker: mismatch");
		$finish;
	end

endmodule
